// ===== hdl/shortest_arc_rotation_quaternion_defines.svh =====
// assertion macros for the shortest-arc rotation quaternion block
`ifndef SHORTEST_ARC_ROTATION_QUATERNION_DEFINES_SVH
`define SHORTEST_ARC_ROTATION_QUATERNION_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SARQ_ASSERT_IMPLY(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SARQ_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hdl/sarq_pkg.sv =====
// shared constants and types of the shortest-arc rotation quaternion block
package sarq_pkg;

    // default component width of the input vectors
    localparam int COMPONENT_BITS_DEF = 24;
    // default fraction bits of the fixed-point results
    localparam int FRACTION_BITS_DEF  = 30;
    // vectors are scaled so their largest magnitude sits just under this bit
    localparam int NORM_BITS          = 30;
    // width of the opposite margin register and its reset value
    localparam int MARGIN_BITS        = 31;
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 31'd1074;
    // width of the quaternion and fallback fields
    localparam int QUAT_BITS          = 32;

    // result case codes
    typedef enum logic [1:0] {
        CASE_IDENTITY  = 2'd0,
        CASE_FALLBACK  = 2'd1,
        CASE_GENERATED = 2'd2,
        CASE_GENERAL   = 2'd3
    } case_code_t;

endpackage

// ===== hdl/sarq_unit_len.sv =====
// pipelined unit-length scaler: normalize, sum of squares, bit-serial sqrt and divide stages
module sarq_unit_len #(
    parameter int LANES = 3,
    parameter int IW    = sarq_pkg::COMPONENT_BITS_DEF,
    parameter int FRAC  = sarq_pkg::FRACTION_BITS_DEF,
    parameter int SW    = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [LANES-1:0][IW-1:0]         in_vec,
    input  logic [SW-1:0]                    in_side,
    output logic                             out_valid,
    output logic                             out_zero,
    output logic [LANES-1:0][FRAC+1:0]       out_unit,
    output logic [SW-1:0]                    out_side
);

    localparam int NB   = sarq_pkg::NORM_BITS;
    localparam int PW   = $clog2(IW);
    localparam int XW   = IW + NB;
    localparam int SHW  = $clog2(XW) + 1;
    localparam int SUMW = 2 * NB + $clog2(LANES);
    localparam int TW   = SUMW + 1;
    localparam int RW   = (SUMW + 1) / 2;
    localparam int QW   = FRAC + 1;
    localparam int DW   = FRAC + NB + 1;
    localparam int UW   = FRAC + 2;
    localparam int CW   = 1 + LANES + LANES * NB + SW;
    localparam int DCW  = 1 + LANES + SW;

    // stage 1: magnitudes and signs
    logic                      v1_reg;
    logic [LANES-1:0][IW-1:0]  mag1_reg;
    logic [LANES-1:0]          sgn1_reg;
    logic [SW-1:0]             side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                sgn1_reg[l] <= in_vec[l][IW-1];
                mag1_reg[l] <= in_vec[l][IW-1] ? (~in_vec[l] + IW'(1)) : in_vec[l];
            end
            side1_reg <= in_side;
        end
    end

    // stage 2: position of the top set bit over all magnitudes
    logic [IW-1:0]             or_mag;
    logic [PW-1:0]             pos_next;
    logic                      v2_reg;
    logic [PW-1:0]             pos2_reg;
    logic                      zero2_reg;
    logic [LANES-1:0][IW-1:0]  mag2_reg;
    logic [LANES-1:0]          sgn2_reg;
    logic [SW-1:0]             side2_reg;

    always_comb begin
        or_mag   = '0;
        pos_next = '0;
        for (int l = 0; l < LANES; l++) begin
            or_mag = or_mag | mag1_reg[l];
        end
        for (int b = 0; b < IW; b++) begin
            if (or_mag[b]) begin
                pos_next = PW'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos2_reg  <= pos_next;
            zero2_reg <= (or_mag == '0);
            mag2_reg  <= mag1_reg;
            sgn2_reg  <= sgn1_reg;
            side2_reg <= side1_reg;
        end
    end

    // stage 3: shift every lane so the largest lies in [2^29, 2^30)
    logic [LANES-1:0][NB-1:0]  norm_next;
    logic                      v3_reg;
    logic [CW-1:0]             car3_reg;

    always_comb begin
        logic [XW-1:0]  ext;
        logic [XW-1:0]  shf;
        logic [SHW-1:0] sh_r;
        logic [SHW-1:0] sh_l;
        sh_r = SHW'(int'(pos2_reg) - (NB - 1));
        sh_l = SHW'((NB - 1) - int'(pos2_reg));
        for (int l = 0; l < LANES; l++) begin
            ext = XW'(mag2_reg[l]);
            if (int'(pos2_reg) >= NB) begin
                shf = ext >> sh_r;
            end else begin
                shf = ext << sh_l;
            end
            norm_next[l] = shf[NB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car3_reg <= {zero2_reg, sgn2_reg, norm_next, side2_reg};
        end
    end

    // stage 4: squares
    logic                        v4_reg;
    logic [LANES-1:0][2*NB-1:0]  sq4_reg;
    logic [CW-1:0]               car4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                sq4_reg[l] <= car3_reg[SW + l * NB +: NB] * car3_reg[SW + l * NB +: NB];
            end
            car4_reg <= car3_reg;
        end
    end

    // stage 5: sum of squares loads the square root chain
    logic [SUMW-1:0] sum_next;
    logic            sv_reg   [0:RW];
    logic [SUMW-1:0] srem_reg [0:RW];
    logic [RW-1:0]   sroot_reg[0:RW];
    logic [CW-1:0]   scar_reg [0:RW];

    always_comb begin
        sum_next = '0;
        for (int l = 0; l < LANES; l++) begin
            sum_next = sum_next + SUMW'(sq4_reg[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            sv_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            srem_reg[0]  <= sum_next;
            sroot_reg[0] <= '0;
            scar_reg[0]  <= car4_reg;
        end
    end

    // square root, one result bit per stage from the top
    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        localparam int K = RW - 1 - i;
        logic [TW-1:0] trial;

        assign trial = (TW'(sroot_reg[i]) << (K + 1)) + (TW'(1) << (2 * K));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[i+1] <= 1'b0;
            end else if (en) begin
                sv_reg[i+1] <= sv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, srem_reg[i]} >= trial) begin
                    srem_reg[i+1]  <= srem_reg[i] - trial[SUMW-1:0];
                    sroot_reg[i+1] <= sroot_reg[i] | (RW'(1) << K);
                end else begin
                    srem_reg[i+1]  <= srem_reg[i];
                    sroot_reg[i+1] <= sroot_reg[i];
                end
                scar_reg[i+1] <= scar_reg[i];
            end
        end
    end

    // divide setup: numerator is |c| * one plus half the root
    logic                     dv_reg  [0:QW];
    logic [LANES-1:0][DW-1:0] drem_reg[0:QW];
    logic [LANES-1:0][QW-1:0] dq_reg  [0:QW];
    logic [RW-1:0]            dr_reg  [0:QW];
    logic [DCW-1:0]           dcar_reg[0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= sv_reg[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                drem_reg[0][l] <= (DW'(scar_reg[RW][SW + l * NB +: NB]) << FRAC)
                                + DW'(sroot_reg[RW] >> 1);
                dq_reg[0][l]   <= '0;
            end
            dr_reg[0]   <= sroot_reg[RW];
            dcar_reg[0] <= {scar_reg[RW][CW-1 -: (1 + LANES)], scar_reg[RW][SW-1:0]};
        end
    end

    // restoring divide, one quotient bit per stage, lanes side by side
    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int B = QW - 1 - i;
        logic [DW-1:0] divisor;

        assign divisor = DW'(dr_reg[i]) << B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_reg[i+1] <= dv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    if (drem_reg[i][l] >= divisor) begin
                        drem_reg[i+1][l] <= drem_reg[i][l] - divisor;
                        dq_reg[i+1][l]   <= dq_reg[i][l] | (QW'(1) << B);
                    end else begin
                        drem_reg[i+1][l] <= drem_reg[i][l];
                        dq_reg[i+1][l]   <= dq_reg[i][l];
                    end
                end
                dr_reg[i+1]   <= dr_reg[i];
                dcar_reg[i+1] <= dcar_reg[i];
            end
        end
    end

    // restore signs
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_unit[l] = dcar_reg[QW][SW + l] ? (UW'(0) - UW'(dq_reg[QW][l]))
                                               : UW'(dq_reg[QW][l]);
        end
    end

    assign out_valid = dv_reg[QW];
    assign out_zero  = dcar_reg[QW][DCW-1];
    assign out_side  = dcar_reg[QW][SW-1:0];

endmodule

// ===== hdl/shortest_arc_rotation_quaternion.sv =====
// top level: shortest-arc rotation quaternion between two vectors, fully pipelined
//
// Input channel (s_valid/s_ready): source vector, destination vector and a
// fallback half-turn axis. Result channel (m_valid/m_ready): unit quaternion
// in fixed point with FRACTION_BITS fraction bits, plus a case code.
// Configuration channel (cfg_valid/cfg_ready, always ready): the opposite
// margin; the user must write it only while no item is in flight, the
// block itself does not enforce this. Throughput: one item per cycle while
// the skid register is empty. The path runs through two unit-length scalers,
// each with a one-bit-per-stage square root chain and a one-bit-per-stage
// divider, around a multiply, add, round and decide stage.
// Reset clears all valid bits and loads the margin with 1074; the pipeline
// comes out of reset empty and ready.
// When the receiver stalls, the waiting item stays in the output register and
// the next finished item parks in a skid register; only then does s_ready
// drop and the whole pipeline hold until the skid drains, losing nothing.
`include "shortest_arc_rotation_quaternion_defines.svh"

module shortest_arc_rotation_quaternion #(
    parameter int COMPONENT_BITS = sarq_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = sarq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [sarq_pkg::MARGIN_BITS-1:0]           cfg_opposite_margin,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [COMPONENT_BITS-1:0]           s_src_x,
    input  logic signed [COMPONENT_BITS-1:0]           s_src_y,
    input  logic signed [COMPONENT_BITS-1:0]           s_src_z,
    input  logic signed [COMPONENT_BITS-1:0]           s_dst_x,
    input  logic signed [COMPONENT_BITS-1:0]           s_dst_y,
    input  logic signed [COMPONENT_BITS-1:0]           s_dst_z,
    input  logic signed [sarq_pkg::QUAT_BITS-1:0]      s_fallback_x,
    input  logic signed [sarq_pkg::QUAT_BITS-1:0]      s_fallback_y,
    input  logic signed [sarq_pkg::QUAT_BITS-1:0]      s_fallback_z,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [sarq_pkg::QUAT_BITS-1:0]      m_quat_w,
    output logic signed [sarq_pkg::QUAT_BITS-1:0]      m_quat_x,
    output logic signed [sarq_pkg::QUAT_BITS-1:0]      m_quat_y,
    output logic signed [sarq_pkg::QUAT_BITS-1:0]      m_quat_z,
    output logic [1:0]                                 m_case_code
);

    localparam int CB    = COMPONENT_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int QB    = sarq_pkg::QUAT_BITS;
    localparam int MB    = sarq_pkg::MARGIN_BITS;
    localparam int UW    = F + 2;
    localparam int PRW   = 2 * UW;
    localparam int SMW   = PRW + 2;
    localparam int RDW   = F + 3;
    localparam int FINW  = (CB + 1 > RDW) ? CB + 1 : RDW;
    localparam int CMPW  = MB + 3;
    localparam int FBW   = 3 * QB;
    localparam int FSW   = 2 + FBW;
    localparam logic signed [QB-1:0] ONE_Q = QB'(1) << F;

    // configuration register
    logic [MB-1:0] margin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= sarq_pkg::MARGIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            margin_reg <= cfg_opposite_margin;
        end
    end

    // pipeline advance: held only while the skid register is occupied
    logic skid_full_reg;
    logic en;

    assign en      = !skid_full_reg;
    assign s_ready = en;

    // normalize source and destination in parallel
    logic                        src_valid;
    logic                        src_zero;
    logic [2:0][UW-1:0]          us;
    logic [FBW-1:0]              src_side;
    logic                        dst_valid;
    logic                        dst_zero;
    logic [2:0][UW-1:0]          ud;
    logic [3*CB-1:0]             dst_side;

    sarq_unit_len #(
        .LANES (3),
        .IW    (CB),
        .FRAC  (F),
        .SW    (FBW)
    ) u_src_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_vec    ({s_src_z, s_src_y, s_src_x}),
        .in_side   ({s_fallback_z, s_fallback_y, s_fallback_x}),
        .out_valid (src_valid),
        .out_zero  (src_zero),
        .out_unit  (us),
        .out_side  (src_side)
    );

    sarq_unit_len #(
        .LANES (3),
        .IW    (CB),
        .FRAC  (F),
        .SW    (3 * CB)
    ) u_dst_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_vec    ({s_dst_z, s_dst_y, s_dst_x}),
        .in_side   ({s_src_z, s_src_y, s_src_x}),
        .out_valid (dst_valid),
        .out_zero  (dst_zero),
        .out_unit  (ud),
        .out_side  (dst_side)
    );

    // multiply stage: dot terms then cross terms
    logic                  mul_valid_reg;
    logic signed [PRW-1:0] mul_prod_reg [0:8];
    logic                  mul_zero_reg;
    logic [FBW-1:0]        mul_fb_reg;
    logic [3*CB-1:0]       mul_src_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_prod_reg[0] <= $signed(us[0]) * $signed(ud[0]);
            mul_prod_reg[1] <= $signed(us[1]) * $signed(ud[1]);
            mul_prod_reg[2] <= $signed(us[2]) * $signed(ud[2]);
            mul_prod_reg[3] <= $signed(us[1]) * $signed(ud[2]);
            mul_prod_reg[4] <= $signed(us[2]) * $signed(ud[1]);
            mul_prod_reg[5] <= $signed(us[2]) * $signed(ud[0]);
            mul_prod_reg[6] <= $signed(us[0]) * $signed(ud[2]);
            mul_prod_reg[7] <= $signed(us[0]) * $signed(ud[1]);
            mul_prod_reg[8] <= $signed(us[1]) * $signed(ud[0]);
            mul_zero_reg    <= src_zero || dst_zero;
            mul_fb_reg      <= src_side;
            mul_src_reg     <= dst_side;
        end
    end

    // add stage: exact dot and cross sums
    logic                  add_valid_reg;
    logic signed [SMW-1:0] add_sum_reg [0:3];
    logic                  add_zero_reg;
    logic [FBW-1:0]        add_fb_reg;
    logic [3*CB-1:0]       add_src_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_valid_reg <= 1'b0;
        end else if (en) begin
            add_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            add_sum_reg[0] <= SMW'(mul_prod_reg[0]) + SMW'(mul_prod_reg[1])
                            + SMW'(mul_prod_reg[2]);
            add_sum_reg[1] <= SMW'(mul_prod_reg[3]) - SMW'(mul_prod_reg[4]);
            add_sum_reg[2] <= SMW'(mul_prod_reg[5]) - SMW'(mul_prod_reg[6]);
            add_sum_reg[3] <= SMW'(mul_prod_reg[7]) - SMW'(mul_prod_reg[8]);
            add_zero_reg   <= mul_zero_reg;
            add_fb_reg     <= mul_fb_reg;
            add_src_reg    <= mul_src_reg;
        end
    end

    // round stage: shift back by the fraction, half away from zero
    logic signed [RDW-1:0] rnd_next [0:3];
    logic                  rnd_valid_reg;
    logic signed [RDW-1:0] rnd_val_reg [0:3];
    logic                  rnd_zero_reg;
    logic [FBW-1:0]        rnd_fb_reg;
    logic [3*CB-1:0]       rnd_src_reg;

    always_comb begin
        logic [SMW:0] mg;
        logic [SMW:0] rs;
        for (int j = 0; j < 4; j++) begin
            mg = add_sum_reg[j][SMW-1] ? ((SMW + 1)'(0) - (SMW + 1)'(add_sum_reg[j]))
                                       : (SMW + 1)'(add_sum_reg[j]);
            rs = (mg + ((SMW + 1)'(1) << (F - 1))) >> F;
            rnd_next[j] = add_sum_reg[j][SMW-1] ? (RDW'(0) - rs[RDW-1:0]) : rs[RDW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (en) begin
            rnd_valid_reg <= add_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_val_reg  <= rnd_next;
            rnd_zero_reg <= add_zero_reg;
            rnd_fb_reg   <= add_fb_reg;
            rnd_src_reg  <= add_src_reg;
        end
    end

    // decide stage: pick the case and the vector for the second scaler
    logic signed [CMPW-1:0] dot_x;
    logic signed [CMPW-1:0] one_x;
    logic signed [CMPW-1:0] thr_x;
    logic                   opposite;
    logic signed [FINW-1:0] sx;
    logic signed [FINW-1:0] sy;
    logic signed [FINW-1:0] sz;
    sarq_pkg::case_code_t   case_next;
    logic [3:0][FINW-1:0]   vec_next;

    always_comb begin
        dot_x    = CMPW'(rnd_val_reg[0]);
        one_x    = CMPW'(1) << F;
        thr_x    = $signed(CMPW'(margin_reg)) - one_x;
        opposite = (dot_x < thr_x) || (dot_x <= -one_x);
        sx       = FINW'($signed(rnd_src_reg[CB-1:0]));
        sy       = FINW'($signed(rnd_src_reg[2*CB-1:CB]));
        sz       = FINW'($signed(rnd_src_reg[3*CB-1:2*CB]));
        vec_next = '0;
        priority if (rnd_zero_reg || dot_x >= one_x) begin
            case_next = sarq_pkg::CASE_IDENTITY;
        end else if (opposite && rnd_fb_reg != '0) begin
            case_next = sarq_pkg::CASE_FALLBACK;
        end else if (opposite) begin
            case_next = sarq_pkg::CASE_GENERATED;
            // half-turn axis from unit x crossed with the source, else unit y
            if (sy == '0 && sz == '0) begin
                vec_next[3] = -sx;
            end else begin
                vec_next[2] = -sz;
                vec_next[3] = sy;
            end
        end else begin
            case_next   = sarq_pkg::CASE_GENERAL;
            vec_next[0] = FINW'(one_x) + FINW'(rnd_val_reg[0]);
            vec_next[1] = FINW'(rnd_val_reg[1]);
            vec_next[2] = FINW'(rnd_val_reg[2]);
            vec_next[3] = FINW'(rnd_val_reg[3]);
        end
    end

    logic                 dec_valid_reg;
    logic [3:0][FINW-1:0] dec_vec_reg;
    logic [FSW-1:0]       dec_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else if (en) begin
            dec_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dec_vec_reg  <= vec_next;
            dec_side_reg <= {case_next, rnd_fb_reg};
        end
    end

    // second scaler: quaternion or generated axis
    logic               fin_valid;
    logic               fin_zero;
    logic [3:0][UW-1:0] fu;
    logic [FSW-1:0]     fin_side;

    sarq_unit_len #(
        .LANES (4),
        .IW    (FINW),
        .FRAC  (F),
        .SW    (FSW)
    ) u_quat_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dec_valid_reg),
        .in_vec    (dec_vec_reg),
        .in_side   (dec_side_reg),
        .out_valid (fin_valid),
        .out_zero  (fin_zero),
        .out_unit  (fu),
        .out_side  (fin_side)
    );

    // result assembly
    sarq_pkg::case_code_t   fin_case;
    logic signed [QB-1:0]   res_w;
    logic signed [QB-1:0]   res_x;
    logic signed [QB-1:0]   res_y;
    logic signed [QB-1:0]   res_z;

    always_comb begin
        fin_case = sarq_pkg::case_code_t'(fin_side[FSW-1 -: 2]);
        res_w    = '0;
        res_x    = '0;
        res_y    = '0;
        res_z    = '0;
        unique case (fin_case)
            sarq_pkg::CASE_IDENTITY: begin
                res_w = ONE_Q;
            end
            sarq_pkg::CASE_FALLBACK: begin
                res_x = fin_side[QB-1:0];
                res_y = fin_side[2*QB-1:QB];
                res_z = fin_side[3*QB-1:2*QB];
            end
            sarq_pkg::CASE_GENERATED: begin
                if (!fin_zero) begin
                    res_x = QB'($signed(fu[1]));
                    res_y = QB'($signed(fu[2]));
                    res_z = QB'($signed(fu[3]));
                end
            end
            sarq_pkg::CASE_GENERAL: begin
                if (fin_zero) begin
                    res_w = ONE_Q;
                end else begin
                    res_w = QB'($signed(fu[0]));
                    res_x = QB'($signed(fu[1]));
                    res_y = QB'($signed(fu[2]));
                    res_z = QB'($signed(fu[3]));
                end
            end
            default: begin
                res_w = ONE_Q;
            end
        endcase
    end

    // output register with skid stage
    logic              m_valid_reg;
    logic [4*QB+1:0]   out_data_reg;
    logic [4*QB+1:0]   skid_data_reg;
    logic [4*QB+1:0]   res_data;

    assign res_data = {fin_case, res_w, res_x, res_y, res_z};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (fin_valid) begin
            if (m_valid_reg && !m_ready) begin
                skid_full_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_ready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (fin_valid) begin
            if (m_valid_reg && !m_ready) begin
                skid_data_reg <= res_data;
            end else begin
                out_data_reg <= res_data;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_case_code = out_data_reg[4*QB+1 -: 2];
    assign m_quat_w    = out_data_reg[4*QB-1 -: QB];
    assign m_quat_x    = out_data_reg[3*QB-1 -: QB];
    assign m_quat_y    = out_data_reg[2*QB-1 -: QB];
    assign m_quat_z    = out_data_reg[QB-1:0];

    // checks
    `SARQ_ASSERT_IMPLY(a_scalers_in_step, 1'b1, src_valid == dst_valid, "scalers out of step")
    `SARQ_ASSERT_IMPLY(a_skid_behind_out, skid_full_reg, m_valid_reg, "skid full with no output")
    `SARQ_ASSERT_NEXT(a_skid_drains, skid_full_reg && m_ready, !skid_full_reg && m_valid_reg, "skid did not drain")
    `SARQ_ASSERT_IMPLY(a_identity_value, m_valid_reg && m_case_code == sarq_pkg::CASE_IDENTITY, m_quat_w == ONE_Q && m_quat_x == '0 && m_quat_y == '0 && m_quat_z == '0, "identity item not identity")

endmodule
